// ===== sv/fula_pkg.sv =====
// Shared constants, codes and helper functions for the fixed-unit free-list allocator.
// Used by the channel interfaces and by the top level; depends on nothing.
package fula_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int MAX_UNITS    = 256;
  localparam int STORE_DEPTH  = MAX_SEGMENTS * MAX_UNITS;

  localparam int SEG_W  = 4;
  localparam int UNIT_W = 8;
  localparam int IDX_W  = SEG_W + UNIT_W;
  localparam int LINK_W = IDX_W + 1;
  localparam int UPS_W  = 9;
  localparam int LIM_W  = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_NO_SEGMENT = 1'b1;

  localparam logic REG_UNITS = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [UPS_W-1:0] UPS_RESET = UPS_W'(256);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

  localparam logic [UPS_W-1:0] UPS_CAP = (MAX_UNITS < 256) ? UPS_W'(MAX_UNITS) : UPS_W'(256);
  localparam logic [LIM_W-1:0] LIM_CAP = (MAX_SEGMENTS < 16) ? LIM_W'(MAX_SEGMENTS) : LIM_W'(16);

  // A programmed unit count of zero acts as one; large values saturate.
  function automatic logic [UPS_W-1:0] eff_units(input logic [UPS_W-1:0] ups);
    logic [UPS_W-1:0] u;
    u = ups;
    if (u == '0) u = UPS_W'(1);
    if (u > UPS_CAP) u = UPS_CAP;
    return u;
  endfunction

  function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] l;
    l = lim;
    if (l > LIM_CAP) l = LIM_CAP;
    return l;
  endfunction

endpackage

// ===== sv/fula_if.sv =====
// Valid/ready channel interfaces for the allocator's request and response beats.
// Depends on fula_pkg for field widths.
interface fula_req_if;
  import fula_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SEG_W-1:0]  free_segment;
  logic [UNIT_W-1:0] free_unit;

  modport source (output valid, opcode, free_segment, free_unit, input ready);
  modport sink   (input valid, opcode, free_segment, free_unit, output ready);
endinterface

interface fula_rsp_if;
  import fula_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [SEG_W-1:0]  unit_segment;
  logic [UNIT_W-1:0] unit_number;

  modport source (output valid, status, unit_segment, unit_number, input ready);
  modport sink   (input valid, status, unit_segment, unit_number, output ready);
endinterface

// ===== sv/fula_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependency.
module fula_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/fixed_unit_free_list_allocator_top.sv =====
// Top level of the fixed-unit free-list allocator: APB registers, request decode,
// free-list head tracking and the response register. Depends on fula_pkg, fula_if, fula_ram.
//
//   Channel  Direction  Handshake        Payload
//   req      in         valid/ready      opcode, free_segment, free_unit
//   rsp      out        valid/ready      status, unit_segment, unit_number
//   apb      in/out     psel/penable     paddr[2:0], pwdata, prdata (pready tied high)
//
// A free, a fresh-unit alloc, a segment grant and a failed alloc are done in the idle state.
// A pop also passes through the link-wait state: the popped unit's link comes back from the
// link RAM in the cycle after the read, and only then is the new head known.
// Reset (rst, synchronous) empties the list and clears the segment and fresh-unit
// counts; the link RAM is not cleared, since only links written by a free are read.
// A new request is taken in the idle state while the response register is empty or is being drained.
module fixed_unit_free_list_allocator_top
  import fula_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fula_req_if.sink    req,
  fula_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LINK = 1'b1;

  // Configuration registers. The register index is the word address, paddr[2].
  logic [UPS_W-1:0] units_per_segment;
  logic [LIM_W-1:0] segment_limit;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      units_per_segment <= UPS_RESET;
      segment_limit     <= LIM_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_UNITS: units_per_segment <= pwdata[UPS_W-1:0];
        REG_LIMIT: segment_limit     <= pwdata[LIM_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_UNITS: prdata = 32'(units_per_segment);
      REG_LIMIT: prdata = 32'(segment_limit);
      default:   prdata = '0;
    endcase
  end

  // Allocator state. free_head holds the index of the top pushed unit plus one,
  // with zero meaning the pushed list is empty.
  logic              state, state_next;
  logic [LINK_W-1:0] free_head, free_head_next;
  logic [LIM_W-1:0]  segments_granted, segments_granted_next;
  logic [UPS_W-1:0]  fresh_next, fresh_next_next;

  logic              rsp_valid, rsp_valid_next;
  logic              rsp_status, rsp_status_next;
  logic [SEG_W-1:0]  rsp_segment, rsp_segment_next;
  logic [UNIT_W-1:0] rsp_unit, rsp_unit_next;

  logic              accept;
  logic [IDX_W-1:0]  push_idx;
  logic [IDX_W-1:0]  head_idx;
  logic [LINK_W-1:0] head_minus_one;
  logic              ram_we, ram_re;
  logic [LINK_W-1:0] ram_rdata;

  // The link RAM is written only by a free and read only by a pop; the two never
  // share a cycle, and the pop's follow-up state holds off any new request until
  // the read data has become the new head.
  assign req.ready      = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept         = req.valid && req.ready;
  assign push_idx       = {req.free_segment, req.free_unit};
  assign head_minus_one = free_head - LINK_W'(1);
  assign head_idx       = head_minus_one[IDX_W-1:0];
  assign ram_we         = accept && (req.opcode == OP_FREE);
  assign ram_re         = accept && (req.opcode == OP_ALLOC) && (free_head != '0);

  fula_ram #(
    .WIDTH (LINK_W),
    .DEPTH (STORE_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (push_idx),
    .wdata (free_head),
    .re    (ram_re),
    .raddr (head_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next            = state;
    free_head_next        = free_head;
    segments_granted_next = segments_granted;
    fresh_next_next       = fresh_next;
    rsp_valid_next        = rsp_valid && !rsp.ready;
    rsp_status_next       = rsp_status;
    rsp_segment_next      = rsp_segment;
    rsp_unit_next         = rsp_unit;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          rsp_valid_next   = 1'b1;
          rsp_status_next  = STATUS_OK;
          rsp_segment_next = '0;
          rsp_unit_next    = '0;
          if (req.opcode == OP_FREE) begin
            free_head_next = LINK_W'(push_idx) + LINK_W'(1);
          end else if (free_head != '0) begin
            // Pop: the result is known now, the next head arrives from the RAM.
            rsp_segment_next = head_idx[IDX_W-1:UNIT_W];
            rsp_unit_next    = head_idx[UNIT_W-1:0];
            state_next       = ST_LINK;
          end else if ((segments_granted != '0) &&
                       (fresh_next < eff_units(units_per_segment))) begin
            rsp_segment_next = SEG_W'(segments_granted - LIM_W'(1));
            rsp_unit_next    = fresh_next[UNIT_W-1:0];
            fresh_next_next  = fresh_next + UPS_W'(1);
          end else if (segments_granted < eff_limit(segment_limit)) begin
            rsp_segment_next      = segments_granted[SEG_W-1:0];
            segments_granted_next = segments_granted + LIM_W'(1);
            fresh_next_next       = UPS_W'(1);
          end else begin
            rsp_status_next = STATUS_NO_SEGMENT;
          end
        end
      end
      ST_LINK: begin
        free_head_next = ram_rdata;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      free_head        <= '0;
      segments_granted <= '0;
      fresh_next       <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      free_head        <= free_head_next;
      segments_granted <= segments_granted_next;
      fresh_next       <= fresh_next_next;
      rsp_valid        <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_status  <= rsp_status_next;
    rsp_segment <= rsp_segment_next;
    rsp_unit    <= rsp_unit_next;
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.unit_segment = rsp_segment;
  assign rsp.unit_number  = rsp_unit;

  // A pop always passes through the link-wait state before the next request.
  a_pop_waits: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (state == ST_LINK) && !req.ready)
    else $error("pop did not wait for the link read");

  // The head never points past the end of the link store.
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= LINK_W'(STORE_DEPTH))
    else $error("free list head out of range");

  // Granted segments never exceed the store's segment count.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    segments_granted <= LIM_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  // A failed alloc reports no unit.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == STATUS_NO_SEGMENT)) |->
      ((rsp_segment == '0) && (rsp_unit == '0)))
    else $error("failed alloc carries a unit");

endmodule

// ===== verif/fixed_unit_free_list_allocator_top_tb.sv =====
// Self-checking testbench for fixed_unit_free_list_allocator_top: random and directed beats
// with bursty idling on both channels, checked against an in-bench allocator predictor.
// Depends on fula_pkg, fula_req_if, fula_rsp_if and the allocator RTL.
module fixed_unit_free_list_allocator_top_tb;
  import fula_pkg::*;

  typedef struct packed {
    logic              opcode;
    logic [SEG_W-1:0]  seg;
    logic [UNIT_W-1:0] unit;
  } alloc_req_t;

  // What the allocator must answer for one request beat. is_alloc only steers the
  // tracking of handed-out units and is not compared.
  typedef struct {
    logic              is_alloc;
    logic              status;
    logic [SEG_W-1:0]  seg;
    logic [UNIT_W-1:0] unit;
  } outcome_t;

  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fula_req_if req_ch ();
  fula_rsp_if rsp_ch ();

  fixed_unit_free_list_allocator_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: a private copy of the link memory, list head, segment count,
  // next fresh unit and both registers. It advances once per accepted request beat.
  logic [LINK_W-1:0] link_mem [STORE_DEPTH];
  logic [LINK_W-1:0] list_head = '0;
  logic [LIM_W-1:0]  seg_count = '0;
  logic [UPS_W-1:0]  fresh_unit = '0;
  logic [UPS_W-1:0]  units_reg;
  logic [LIM_W-1:0]  limit_reg;

  alloc_req_t requests_pending [$];
  outcome_t   outcomes_due [$];
  int         units_on_loan [$];   // store indexes handed out and not yet freed
  alloc_req_t on_bus;

  int fault_count = 0;
  int stall_cycles = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int gap_odds = 4;          // one chance in gap_odds of an idle burst after a beat, 0 = never
  bit loan_tracking = 1'b0;

  // A unit count of zero acts as one; counts above the store's row size saturate.
  function automatic int units_now();
    int u;
    int cap;
    u = int'(units_reg);
    cap = (MAX_UNITS < 256) ? MAX_UNITS : 256;
    if (u == 0) u = 1;
    if (u > cap) u = cap;
    return u;
  endfunction

  function automatic int limit_now();
    int l;
    int cap;
    l = int'(limit_reg);
    cap = (MAX_SEGMENTS < 16) ? MAX_SEGMENTS : 16;
    if (l > cap) l = cap;
    return l;
  endfunction

  // Apply one request to the predictor state and return the answer it calls for.
  // The order of the alloc branches matters: pushed units first, then the fresh
  // units of the newest segment, then a new segment, and only then a failure.
  function automatic outcome_t allocator_outcome(alloc_req_t r);
    outcome_t o;
    int idx;
    o.is_alloc = (r.opcode == OP_ALLOC);
    o.status = STATUS_OK;
    o.seg = '0;
    o.unit = '0;
    if (r.opcode == OP_FREE) begin
      idx = int'(r.seg) * MAX_UNITS + int'(r.unit);
      link_mem[idx] = list_head;
      list_head = LINK_W'(idx + 1);
    end else if (list_head != '0) begin
      idx = int'(list_head) - 1;
      list_head = link_mem[idx];
      o.seg = SEG_W'(idx / MAX_UNITS);
      o.unit = UNIT_W'(idx % MAX_UNITS);
    end else if (seg_count != '0 && int'(fresh_unit) < units_now()) begin
      o.seg = SEG_W'(seg_count - 1'b1);
      o.unit = UNIT_W'(fresh_unit);
      fresh_unit = fresh_unit + 1'b1;
    end else if (int'(seg_count) < limit_now()) begin
      o.seg = SEG_W'(seg_count);
      seg_count = seg_count + 1'b1;
      fresh_unit = UPS_W'(1);
    end else begin
      o.status = STATUS_NO_SEGMENT;
    end
    return o;
  endfunction

  // True when the unit already sits on the predicted free list. The walk is bounded,
  // since a deliberate double free leaves the list circular.
  function automatic bit on_free_list(int idx);
    logic [LINK_W-1:0] walk;
    int steps;
    walk = list_head;
    steps = 0;
    while (walk != '0 && steps < STORE_DEPTH) begin
      if (int'(walk) - 1 == idx) return 1'b1;
      walk = link_mem[int'(walk) - 1];
      steps++;
    end
    return 1'b0;
  endfunction

  // Request driver. A beat is accepted at an edge where valid and ready are both
  // high; the predictor runs right then, so expectations follow acceptance order.
  // Ready is sampled before the block's own updates of this edge take effect.
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_ALLOC;
      req_ch.free_segment <= '0;
      req_ch.free_unit <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) outcomes_due.push_back(allocator_outcome(on_bus));
      if (!req_ch.valid || req_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_ch.valid <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          on_bus = requests_pending.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= on_bus.opcode;
          req_ch.free_segment <= on_bus.seg;
          req_ch.free_unit <= on_bus.unit;
          // The idle burst, if any, starts once this beat has gone through.
          if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            src_gap = $urandom_range(1, 8);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and ready driver. Every response beat is compared with the
  // oldest expectation, field by field; a beat with nothing expected is a fault.
  always @(posedge clk) begin : check_responses
    outcome_t want;
    int hits[$];
    int idx;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcomes_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected response beat: status %0d segment %0d unit %0d",
                     rsp_ch.status, rsp_ch.unit_segment, rsp_ch.unit_number);
        end else begin
          want = outcomes_due.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.unit_segment !== want.seg ||
              rsp_ch.unit_number !== want.unit) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d (status/seg/unit)",
                       want.status, want.seg, want.unit,
                       rsp_ch.status, rsp_ch.unit_segment, rsp_ch.unit_number);
          end else if (loan_tracking && want.is_alloc && want.status == STATUS_OK) begin
            // Remember the unit once, so that the stimulus can hand it back later.
            idx = int'(want.seg) * MAX_UNITS + int'(want.unit);
            hits = units_on_loan.find_first_index(x) with (x == idx);
            if (hits.size() == 0) units_on_loan.push_back(idx);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
          sink_gap = $urandom_range(1, 8);
      end
    end
  end

  // Watchdog: the run ends once the stall count, cleared whenever a beat or a register
  // write goes through, reaches STALL_LIMIT. Idle bursts end long before that, so this is far
  // beyond any correct run.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL fixed_unit_free_list_allocator_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Wait until every queued beat has been taken and every response has come back.
  // Sampling at the falling edge keeps this clear of the clocked processes.
  task automatic drain_all();
    while (requests_pending.size() != 0 || req_ch.valid || outcomes_due.size() != 0)
      @(negedge clk);
  endtask

  // Register write: a setup cycle, then an access cycle that completes with pready.
  task automatic write_register(logic sel, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(sel));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_UNITS) units_reg = value[UPS_W-1:0];
    else limit_reg = value[LIM_W-1:0];
  endtask

  // Both registers are written with the block idle: all responses in, then a wait
  // until any pop's link-wait state is over.
  task automatic set_registers(int units, int limit);
    drain_all();
    repeat (4) @(posedge clk);
    write_register(REG_UNITS, 32'(units));
    write_register(REG_LIMIT, 32'(limit));
  endtask

  task automatic queue_beat(logic op, int seg, int unit);
    alloc_req_t r;
    r.opcode = op;
    r.seg = SEG_W'(seg);
    r.unit = UNIT_W'(unit);
    while (requests_pending.size() >= 2) @(negedge clk);
    requests_pending.push_back(r);
  endtask

  // One random beat. Most frees hand back a unit that is out on loan; a few are
  // stray frees of units that were never handed out, or that were dropped from
  // tracking. Stray frees wait for the predictor to catch up so that a unit already
  // on the list, or one that a later fresh alloc would still hand out, is never
  // pushed; either would make the list circular and shut off the deeper paths.
  task automatic queue_random_beat(int alloc_pct);
    int roll;
    int pick;
    int idx;
    int top_seg;
    int seg;
    int unit;
    logic op;
    roll = $urandom_range(0, 99);
    op = OP_ALLOC;
    seg = $urandom_range(0, MAX_SEGMENTS - 1);
    unit = $urandom_range(0, MAX_UNITS - 1);
    if (roll >= alloc_pct && roll < alloc_pct + 6) begin
      drain_all();
      if (seg_count != '0) begin
        top_seg = int'(seg_count) - 1;
        seg = $urandom_range(0, top_seg);
        if (seg == top_seg) unit = $urandom_range(0, int'(fresh_unit) - 1);
        idx = seg * MAX_UNITS + unit;
        if (!on_free_list(idx)) begin
          op = OP_FREE;
          units_on_loan = units_on_loan.find(x) with (x != idx);
        end
      end
    end else if (roll >= alloc_pct && units_on_loan.size() != 0) begin
      pick = $urandom_range(0, units_on_loan.size() - 1);
      idx = units_on_loan[pick];
      units_on_loan.delete(pick);
      op = OP_FREE;
      seg = idx / MAX_UNITS;
      unit = idx % MAX_UNITS;
    end
    queue_beat(op, seg, unit);
  endtask

  task automatic run_phase(int units, int limit, int beats, int alloc_pct, int odds);
    set_registers(units, limit);
    gap_odds = odds;
    repeat (beats) queue_random_beat(alloc_pct);
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    units_reg = UPS_RESET;
    limit_reg = LIM_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part with three units per segment and two segments: grants, fresh
    // units, running out, frees of a never-allocated unit at the top corner of the
    // store, and allocs that carry junk in the ignored free fields.
    set_registers(3, 2);
    queue_beat(OP_ALLOC, 15, 255);   // new segment 0, unit 0
    queue_beat(OP_ALLOC, 0, 0);      // fresh unit 1
    queue_beat(OP_ALLOC, 9, 170);    // fresh unit 2
    queue_beat(OP_ALLOC, 6, 85);     // segment 0 used up: new segment 1
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_ALLOC, 15, 255);
    queue_beat(OP_ALLOC, 0, 0);      // no segment left: failure
    queue_beat(OP_FREE, 0, 1);
    queue_beat(OP_FREE, 15, 255);    // never handed out, pushed all the same
    queue_beat(OP_ALLOC, 0, 0);      // pops 15/255
    queue_beat(OP_ALLOC, 0, 0);      // pops 0/1
    queue_beat(OP_ALLOC, 15, 255);   // list empty and no segment: failure
    queue_beat(OP_FREE, 0, 0);
    queue_beat(OP_ALLOC, 0, 0);
    // A limit of zero below the segments already granted fails straight away.
    set_registers(3, 0);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_FREE, 1, 2);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_ALLOC, 0, 0);
    drain_all();
    loan_tracking = 1'b1;

    // Random phases. Each changes the registers mid-segment, so the fresh units of
    // the newest segment run up to whatever count is in force. The settings cover
    // zero units, saturation of both registers and the largest legal values.
    run_phase(0, 4, 200, 60, 6);
    run_phase(511, 5, 320, 65, 3);
    run_phase(7, 31, 300, 60, 10);
    run_phase(256, 0, 200, 55, 4);
    run_phase(1, 16, 250, 60, 8);

    // Last part, with no idling: a double free, after which the popped unit's link
    // points back at itself and allocs keep returning it, then random beats.
    set_registers(2, 16);
    gap_odds = 0;
    queue_beat(OP_FREE, 3, 5);
    queue_beat(OP_FREE, 3, 5);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_ALLOC, 0, 0);
    repeat (130) queue_random_beat(60);

    drain_all();
    repeat (8) @(posedge clk);
    if (fault_count == 0 && outcomes_due.size() == 0) begin
      $display("PASS fixed_unit_free_list_allocator_top");
    end else begin
      $display("FAIL fixed_unit_free_list_allocator_top");
    end
    $finish;
  end

endmodule
